/* src/mupd_pkg.sv */
// Shared types and constants of the multi-unit priority dispatcher.
package mupd_pkg;

	localparam int IdW   = 16;
	localparam int PriW  = 8;
	localparam int TickW = 16;
	localparam int LenW  = 16;
	localparam int CntW  = 4;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_START  = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [IdW-1:0]   job_id;
		logic [PriW-1:0]  job_priority;
		logic [TickW-1:0] job_arrival;
		logic [LenW-1:0]  job_length;
	} in_item_t;

	typedef struct packed {
		logic             accepted;
		logic [2:0]       unit_index;
		logic             unit_busy;
		logic [IdW-1:0]   running_id;
		logic             run_done;
		logic             last;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FIND,
		ST_SHIFT,
		ST_COUNT,
		ST_UNIT,
		ST_SCAN,
		ST_TAKE,
		ST_REPORT,
		ST_EMIT
	} state_t;

endpackage

/* src/mupd_if.sv */
// Valid/ready channel interfaces for commands, results and configuration.
interface mupd_in_if;
	import mupd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mupd_out_if;
	import mupd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mupd_cfg_if;
	import mupd_pkg::*;
	logic            valid;
	logic            ready;
	logic [CntW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/mupd_queue.sv */
// Short FIFO between the command front end and the execution back end.
module mupd_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mupd_pkg::in_item_t  push_data,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output mupd_pkg::in_item_t  pop_data
);
	import mupd_pkg::*;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_item_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;

	assign full     = (cnt_q == (AW+1)'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
		end
	end
endmodule

/* src/mupd_engine.sv */
// Back end: job table, units and the sequencer that carries out commands.
module mupd_engine #(
	parameter int MAX_JOBS  = 16,
	parameter int MAX_UNITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  mupd_pkg::in_item_t    cmd_data,
	output logic                  cmd_pop,
	input  logic [mupd_pkg::CntW-1:0] unit_count,
	output logic                  res_valid,
	output mupd_pkg::out_item_t   res_data,
	input  logic                  res_ready,
	output logic                  busy
);
	import mupd_pkg::*;
	localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int UW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

	logic [IdW-1:0]   eid_q  [MAX_JOBS];
	logic [PriW-1:0]  epri_q [MAX_JOBS];
	logic [TickW-1:0] earr_q [MAX_JOBS];
	logic [LenW-1:0]  elen_q [MAX_JOBS];
	logic [JW:0]      pcnt_q;

	logic             uact_q [MAX_UNITS];
	logic [IdW-1:0]   ujob_q [MAX_UNITS];
	logic [LenW-1:0]  urem_q [MAX_UNITS];
	logic [TickW-1:0] now_q;

	state_t           st_q, st_d;
	in_item_t         cur_q;
	logic [JW:0]      j_q;
	logic [JW-1:0]    best_q;
	logic             found_q, hit_q, running_q;
	logic [UW:0]      u_q;
	logic [UW:0]      n_q;
	logic             ov_q;
	out_item_t        ov_data_q;

	logic [JW-1:0] jx;
	logic [UW-1:0] ux;
	assign jx = j_q[JW-1:0];
	assign ux = u_q[UW-1:0];

	// effective unit count
	logic [UW:0] n_eff;
	always_comb begin
		if (unit_count == '0) n_eff = (UW+1)'(1);
		else if (32'(unit_count) > MAX_UNITS) n_eff = (UW+1)'(MAX_UNITS);
		else n_eff = (UW+1)'(unit_count);
	end

	logic out_free;
	logic ov_load;
	logic add_ok;
	out_item_t res_d;
	assign out_free  = !ov_q || res_ready;
	assign ov_load   = out_free && (st_q == ST_REPORT || st_q == ST_EMIT);
	assign add_ok    = !hit_q && cur_q.job_length != '0 && 32'(pcnt_q) < MAX_JOBS;
	assign res_valid = ov_q;
	assign res_data  = ov_data_q;
	assign busy      = (st_q != ST_IDLE) || ov_q;
	assign cmd_pop   = (st_q == ST_IDLE) && cmd_valid;

	// result word for the unit report or the single command result
	always_comb begin
		res_d = '0;
		res_d.last = 1'b1;
		if (st_q == ST_REPORT) begin
			res_d.accepted   = 1'b1;
			res_d.unit_index = 3'(u_q);
			res_d.unit_busy  = uact_q[ux];
			res_d.running_id = uact_q[ux] ? ujob_q[ux] : '0;
			res_d.last       = (u_q + 1'b1 >= n_q);
		end else begin
			unique case (cmd_t'(cur_q.cmd))
				CMD_ADD:    res_d.accepted = add_ok;
				CMD_REMOVE: res_d.accepted = hit_q;
				CMD_TICK: begin
					res_d.accepted = 1'b1;
					res_d.run_done = 1'b1;
				end
				CMD_START:  res_d.accepted = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (cmd_valid) st_d = (cmd_data.cmd == CMD_TICK) ? ST_COUNT :
			                   (cmd_data.cmd == CMD_START) ? ST_EMIT : ST_FIND;
			ST_FIND:   if (j_q >= pcnt_q || hit_q)
			                   st_d = (hit_q && cur_q.cmd == CMD_REMOVE) ? ST_SHIFT : ST_EMIT;
			ST_SHIFT:  if (j_q + 1'b1 >= pcnt_q)
			                   st_d = (u_q == '0 && cur_q.cmd != CMD_TICK) ? ST_EMIT : ST_UNIT;
			ST_COUNT:  if (u_q >= n_q) st_d = ST_UNIT;
			ST_UNIT:   begin
				if (!running_q && pcnt_q == '0 && u_q == '0 && !found_q) st_d = ST_EMIT;
				else if (u_q >= n_q) st_d = ST_REPORT;
				else if (uact_q[ux]) st_d = ST_UNIT;
				else st_d = ST_SCAN;
			end
			ST_SCAN:   if (j_q >= pcnt_q) st_d = found_q ? ST_TAKE : ST_UNIT;
			ST_TAKE:   st_d = ST_SHIFT;
			ST_REPORT: if (out_free && u_q + 1'b1 >= n_q) st_d = ST_IDLE;
			ST_EMIT:   if (out_free) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			pcnt_q    <= '0;
			now_q     <= '0;
			ov_q      <= 1'b0;
			ov_data_q <= '0;
			j_q       <= '0;
			u_q       <= '0;
			n_q       <= '0;
			best_q    <= '0;
			found_q   <= 1'b0;
			hit_q     <= 1'b0;
			running_q <= 1'b0;
			for (int i = 0; i < MAX_UNITS; i++) begin
				uact_q[i] <= 1'b0;
				ujob_q[i] <= '0;
				urem_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			ov_q <= (ov_q && !res_ready) || ov_load;
			if (ov_load) ov_data_q <= res_d;
			unique case (st_q)
				ST_IDLE: if (cmd_valid) begin
					j_q <= '0; u_q <= '0; found_q <= 1'b0; hit_q <= 1'b0;
					running_q <= 1'b0; n_q <= n_eff;
				end
				ST_FIND: if (!(j_q >= pcnt_q || hit_q)) begin
					if (eid_q[jx] == cur_q.job_id) hit_q <= 1'b1;
					else j_q <= j_q + 1'b1;
				end
				ST_SHIFT: begin
					// drop entry j by shifting later ones down
					if (j_q + 1'b1 >= pcnt_q) begin
						pcnt_q <= pcnt_q - 1'b1;
						j_q <= '0; found_q <= 1'b0;
						if (cur_q.cmd == CMD_TICK) u_q <= u_q + 1'b1;
					end else j_q <= j_q + 1'b1;
				end
				ST_COUNT: if (u_q < n_q) begin
					if (uact_q[ux]) begin
						if (urem_q[ux] <= LenW'(1)) begin
							uact_q[ux] <= 1'b0; ujob_q[ux] <= '0; urem_q[ux] <= '0;
						end else begin
							urem_q[ux] <= urem_q[ux] - 1'b1;
							running_q <= 1'b1;
						end
					end
					u_q <= u_q + 1'b1;
				end else u_q <= '0;
				ST_UNIT: begin
					// the no-work check only matters on the first unit visit of a tick
					if (!running_q && pcnt_q == '0 && u_q == '0 && !found_q) begin
					end else if (u_q >= n_q) u_q <= '0;
					else if (uact_q[ux]) u_q <= u_q + 1'b1;
					else begin j_q <= '0; found_q <= 1'b0; end
				end
				ST_SCAN: if (j_q < pcnt_q) begin
					if (earr_q[jx] <= now_q &&
					    (!found_q || epri_q[jx] > epri_q[best_q])) begin
						found_q <= 1'b1; best_q <= jx;
					end
					j_q <= j_q + 1'b1;
				end else if (!found_q) u_q <= u_q + 1'b1;
				ST_TAKE: begin
					uact_q[ux] <= 1'b1;
					ujob_q[ux] <= eid_q[best_q];
					urem_q[ux] <= elen_q[best_q];
					running_q  <= 1'b1;
					j_q <= {1'b0, best_q};
				end
				ST_REPORT: if (out_free) begin
					u_q <= u_q + 1'b1;
					if (u_q + 1'b1 >= n_q && now_q != '1) now_q <= now_q + 1'b1;
				end
				ST_EMIT: if (out_free) begin
					unique case (cur_q.cmd)
						CMD_ADD: if (add_ok) pcnt_q <= pcnt_q + 1'b1;
						CMD_START: begin
							now_q <= '0;
							for (int i = 0; i < MAX_UNITS; i++) begin
								uact_q[i] <= 1'b0; ujob_q[i] <= '0; urem_q[i] <= '0;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	// payload: current command and table storage
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && cmd_valid) cur_q <= cmd_data;
		if (st_q == ST_SHIFT && j_q + 1'b1 < pcnt_q) begin
			eid_q[jx]  <= eid_q[jx + 1'b1];
			epri_q[jx] <= epri_q[jx + 1'b1];
			earr_q[jx] <= earr_q[jx + 1'b1];
			elen_q[jx] <= elen_q[jx + 1'b1];
		end
		if (st_q == ST_EMIT && out_free && cur_q.cmd == CMD_ADD && add_ok) begin
			eid_q[pcnt_q[JW-1:0]]  <= cur_q.job_id;
			epri_q[pcnt_q[JW-1:0]] <= cur_q.job_priority;
			earr_q[pcnt_q[JW-1:0]] <= cur_q.job_arrival;
			elen_q[pcnt_q[JW-1:0]] <= cur_q.job_length;
		end
	end
endmodule

/* src/multi_unit_priority_dispatcher.sv */
// Top level of the multi-unit priority dispatcher.
// Commands (add, remove, tick, start) enter a two-entry queue and are executed
// one at a time by a sequencer over a table of MAX_JOBS pending jobs and
// MAX_UNITS execution units. Add and remove scan the table one entry per cycle,
// and a remove then shifts later entries down one per cycle. A tick first counts
// down the N units in use, then for each free unit picks it, scans for the best
// arrived job, takes it and shifts it out of the table, then reports each unit;
// with no pending job and no busy unit it gives a single done result instead.
// The table scan is the limiting loop. unit_count is written through cfg, which
// is ready only while the queue is empty and the engine is idle. Results leave
// through a register, so the queue may keep filling while a result waits.
module multi_unit_priority_dispatcher #(
	parameter int MAX_JOBS  = 16,
	parameter int MAX_UNITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	mupd_in_if.sink    cmd_in,
	mupd_out_if.source res_out,
	mupd_cfg_if.sink   cfg
);
	import mupd_pkg::*;

	logic [CntW-1:0] unit_count_q;
	logic            q_full, q_empty, q_pop, eng_busy;
	in_item_t        q_data;

	// accept a config transaction only with nothing in flight
	assign cfg.ready    = q_empty && !eng_busy;
	assign cmd_in.ready = !q_full;

	// hold the unit count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) unit_count_q <= CntW'(1);
		else if (cfg.valid && cfg.ready) unit_count_q <= cfg.data;
	end

	mupd_queue #(.DEPTH(2)) u_queue (
		.clk, .arst_n,
		.push(cmd_in.valid), .push_data(cmd_in.data), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_data(q_data)
	);

	mupd_engine #(.MAX_JOBS(MAX_JOBS), .MAX_UNITS(MAX_UNITS)) u_engine (
		.clk, .arst_n,
		.cmd_valid(!q_empty), .cmd_data(q_data), .cmd_pop(q_pop),
		.unit_count(unit_count_q),
		.res_valid(res_out.valid), .res_data(res_out.data), .res_ready(res_out.ready),
		.busy(eng_busy)
	);
endmodule

/* src/mupd_checker.sv */
// Port-level assertions for the dispatcher, bound to the top level.
module mupd_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input mupd_pkg::out_item_t out_data
);
	import mupd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.run_done |-> out_data.last && out_data.accepted)
		else $error("done result not final");
	a_idle_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.unit_busy |-> out_data.running_id == '0)
		else $error("idle unit with id");
	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result during reset");
endmodule

bind multi_unit_priority_dispatcher mupd_checker u_chk (
	.clk, .arst_n,
	.out_valid(res_out.valid), .out_ready(res_out.ready), .out_data(res_out.data)
);

/* sim/dispatch_checker.sv */
`timescale 1ns / 1ps
// Checker for the dispatcher: tracks command, result and config transactions and compares.
module dispatch_checker
	import mupd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_item_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_item_t out_data,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [CntW-1:0] cfg_data,
	output int errors,
	output int outstanding
);
	localparam int JOBS  = 16;
	localparam int UNITS = 8;

	logic [IdW-1:0]   tbl_id [JOBS];
	logic [PriW-1:0]  tbl_pri [JOBS];
	logic [TickW-1:0] tbl_arr [JOBS];
	logic [LenW-1:0]  tbl_len [JOBS];
	int               n_pending;
	logic             u_on [UNITS];
	logic [IdW-1:0]   u_job [UNITS];
	logic [LenW-1:0]  u_left [UNITS];
	logic [TickW-1:0] clock_now;
	logic [CntW-1:0]  units_cfg;
	out_item_t        awaited_results [$];

	function automatic int lookup(logic [IdW-1:0] id);
		for (int j = 0; j < n_pending; j++)
			if (tbl_id[j] == id) return j;
		return -1;
	endfunction

	function automatic void remove_at(int pos);
		for (int j = pos; j + 1 < n_pending; j++) begin
			tbl_id[j] = tbl_id[j+1];
			tbl_pri[j] = tbl_pri[j+1];
			tbl_arr[j] = tbl_arr[j+1];
			tbl_len[j] = tbl_len[j+1];
		end
		n_pending--;
	endfunction

	function automatic void push_res(logic acc, logic [2:0] idx, logic busy,
			logic [IdW-1:0] id, logic done, logic lst);
		out_item_t r;
		r.accepted = acc; r.unit_index = idx; r.unit_busy = busy;
		r.running_id = id; r.run_done = done; r.last = lst;
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	function automatic void clear_units();
		for (int i = 0; i < UNITS; i++) begin
			u_on[i] = 0; u_job[i] = '0; u_left[i] = '0;
		end
		clock_now = '0;
	endfunction

	// Advance the predicted dispatcher by one command.
	function automatic void dispatch_step(in_item_t c);
		int n, pos, best;
		logic busy_left, found;
		case (cmd_t'(c.cmd))
			CMD_ADD: begin
				found = c.job_length != 0 && lookup(c.job_id) < 0 && n_pending < JOBS;
				if (found) begin
					tbl_id[n_pending] = c.job_id; tbl_pri[n_pending] = c.job_priority;
					tbl_arr[n_pending] = c.job_arrival; tbl_len[n_pending] = c.job_length;
					n_pending++;
				end
				push_res(found, 0, 0, 0, 0, 1);
			end
			CMD_REMOVE: begin
				pos = lookup(c.job_id);
				if (pos >= 0) remove_at(pos);
				push_res(pos >= 0, 0, 0, 0, 0, 1);
			end
			CMD_START: begin
				clear_units();
				push_res(1, 0, 0, 0, 0, 1);
			end
			default: begin
				n = units_cfg < 1 ? 1 : (units_cfg > UNITS ? UNITS : int'(units_cfg));
				busy_left = 0;
				for (int i = 0; i < n; i++) begin
					if (!u_on[i]) continue;
					if (u_left[i] <= 1) begin
						u_on[i] = 0; u_job[i] = '0; u_left[i] = '0;
					end else begin
						u_left[i]--; busy_left = 1;
					end
				end
				if (n_pending == 0 && !busy_left) begin
					push_res(1, 0, 0, 0, 1, 1);
					return;
				end
				for (int i = 0; i < n; i++) begin
					if (u_on[i]) continue;
					found = 0; best = 0;
					for (int j = 0; j < n_pending; j++) begin
						if (tbl_arr[j] > clock_now) continue;
						if (!found || tbl_pri[j] > tbl_pri[best]) begin
							found = 1; best = j;
						end
					end
					if (found) begin
						u_on[i] = 1; u_job[i] = tbl_id[best]; u_left[i] = tbl_len[best];
						remove_at(best);
					end
				end
				for (int i = 0; i < n; i++)
					push_res(1, i[2:0], u_on[i], u_on[i] ? u_job[i] : '0, 0, i + 1 == n);
				if (clock_now != 16'hFFFF) clock_now++;
			end
		endcase
	endfunction

	assign outstanding = awaited_results.size();

	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		if (!arst_n) begin
			errors <= 0;
			n_pending = 0;
			clear_units();
			units_cfg = 1;
			awaited_results.delete();
		end else begin
			if (cfg_valid && cfg_ready) units_cfg = cfg_data;
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result %h", $time, out_data);
					errors <= errors + 1;
				end else begin
					exp_r = awaited_results.pop_front();
					if (exp_r !== out_data) begin
						$display("%0t: result mismatch expected %h actual %h",
							$time, exp_r, out_data);
						errors <= errors + 1;
					end
				end
			end
			if (in_valid && in_ready) dispatch_step(in_data);
		end
	end
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Top-level testbench: clock, reset, command stimulus, sink stalls and verdict.
module tb;
	import mupd_pkg::*;

	logic clk = 0;
	logic arst_n = 1;
	int   errors, outstanding;
	int   hold_cycles = 0;   // long sink hold-off, counted in its own process
	bit   cmds_done = 0;
	logic [15:0] id_pool [8];

	mupd_in_if  cmd_ch ();
	mupd_out_if res_ch ();
	mupd_cfg_if cfg_ch ();

	multi_unit_priority_dispatcher u_dut (
		.clk(clk), .arst_n(arst_n), .cmd_in(cmd_ch), .res_out(res_ch), .cfg(cfg_ch)
	);

	dispatch_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(cmd_ch.valid), .in_ready(cmd_ch.ready), .in_data(cmd_ch.data),
		.out_valid(res_ch.valid), .out_ready(res_ch.ready), .out_data(res_ch.data),
		.cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data),
		.errors(errors), .outstanding(outstanding)
	);

	always #4 clk = ~clk;

	initial begin
		cmd_ch.valid = 0; cmd_ch.data = '0;
		cfg_ch.valid = 0; cfg_ch.data = '0;
		res_ch.ready = 0;
	end

	// Send one command transaction after a random gap; hold valid until accepted.
	task automatic send_cmd(cmd_t c, logic [15:0] id, logic [7:0] pri,
			logic [15:0] arr, logic [15:0] len);
		in_item_t it;
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
		repeat (gap) @(posedge clk);
		it.cmd = c; it.job_id = id; it.job_priority = pri;
		it.job_arrival = arr; it.job_length = len;
		cmd_ch.valid <= 1;
		cmd_ch.data <= it;
		do @(posedge clk); while (!cmd_ch.ready);
		cmd_ch.valid <= 0;
	endtask

	// Drain outstanding results, let the sequencer settle, then write the unit count.
	task automatic set_units(logic [3:0] v);
		while (outstanding != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		cfg_ch.valid <= 1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
	endtask

	// Random job command: mostly reuse a small id pool so removes and duplicates hit.
	task automatic random_cmd();
		int r;
		logic [15:0] id;
		r = $urandom_range(0, 99);
		id = $urandom_range(0, 4) == 0 ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
		if (r < 40)
			send_cmd(CMD_ADD, id, 8'($urandom),
				$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12)),
				$urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 1) ? 0 : 16'hFFFF)
					: 16'($urandom_range(1, 5)));
		else if (r < 55)
			send_cmd(CMD_REMOVE, id, 8'($urandom), 16'($urandom), 16'($urandom));
		else if (r < 95)
			send_cmd(CMD_TICK, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
		else
			send_cmd(CMD_START, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Sink: random per-transaction stall, with one long hold-off during the pressure phase.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				res_ch.ready <= 0;
				repeat (hold_cycles) @(posedge clk);
				hold_cycles = 0;
			end
			stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				res_ch.ready <= 0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin
		arst_n <= 0;
		for (int i = 0; i < 8; i++) id_pool[i] = 16'($urandom);
		id_pool[0] = 16'h0000;
		id_pool[1] = 16'hFFFF;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty tick, bad adds, extremes, arrival gating, duplicates, full table.
		send_cmd(CMD_TICK, 0, 0, 0, 0);
		send_cmd(CMD_ADD, 16'h0001, 8'h00, 16'h0000, 16'h0000);
		send_cmd(CMD_REMOVE, 16'h1234, 0, 0, 0);
		send_cmd(CMD_ADD, 16'hFFFF, 8'hFF, 16'h0000, 16'h0002);
		send_cmd(CMD_ADD, 16'hFFFF, 8'h10, 16'h0000, 16'h0001);
		send_cmd(CMD_ADD, 16'h0000, 8'hFF, 16'h0000, 16'h0001);
		send_cmd(CMD_ADD, 16'h0002, 8'h01, 16'h0003, 16'h0001);
		send_cmd(CMD_ADD, 16'h0003, 8'h80, 16'hFFFF, 16'hFFFF);
		repeat (4) send_cmd(CMD_TICK, 0, 0, 0, 0);
		send_cmd(CMD_REMOVE, 16'h0003, 0, 0, 0);
		send_cmd(CMD_REMOVE, 16'h0003, 0, 0, 0);
		send_cmd(CMD_START, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		for (int i = 0; i < 17; i++)
			send_cmd(CMD_ADD, 16'(16'h100 + i), 8'(i * 15), 0, 16'(1 + i % 3));

		set_units(4'd8);
		repeat (6) send_cmd(CMD_TICK, 0, 0, 0, 0);
		set_units(4'd0);
		repeat (3) send_cmd(CMD_TICK, 0, 0, 0, 0);
		set_units(4'd15);
		send_cmd(CMD_START, 0, 0, 0, 0);

		// Pressure: hold the sink off while ticks keep coming so the input backs up.
		hold_cycles = 600;
		repeat (6) send_cmd(CMD_TICK, 0, 0, 0, 0);

		for (int ph = 0; ph < 4; ph++) begin
			set_units(ph == 0 ? 4'd3 : ph == 1 ? 4'd1 : ph == 2 ? 4'd8 : 4'd5);
			repeat (13) random_cmd();
		end
		// Run out the clock to the saturation limit of the tick counter is too long;
		// drain the table instead.
		repeat (10) send_cmd(CMD_TICK, 0, 0, 0, 0);
		cmds_done = 1;
	end

	initial begin
		wait (cmds_done);
		while (outstanding != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#8000000;
		$display("tb: FAIL");
		$finish;
	end
endmodule

/* filelist.f */
src/mupd_pkg.sv
src/mupd_if.sv
src/mupd_queue.sv
src/mupd_engine.sv
src/multi_unit_priority_dispatcher.sv
src/mupd_checker.sv
sim/dispatch_checker.sv
sim/tb.sv
